// ===== rtl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement: shared types and constants
// Frame geometry, the scan beat that walks the cell chain, and the write-back
// beat that updates one frame.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;
    localparam int STAMP_W   = 32;
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FC_W      = 5;

    localparam logic [FC_W-1:0]    FRAME_COUNT_RST = FC_W'(4);
    localparam logic [STAMP_W-1:0] STAMP_MAX       = '1;

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [STAMP_W-1:0]   stamp_t;
    typedef logic [IDX_W-1:0]     idx_t;

    typedef struct packed {
        logic   vld;
        page_t  page;
        logic   found;
        idx_t   slot;
        stamp_t best;
    } token_t;

    typedef struct packed {
        logic   en;
        idx_t   slot;
        page_t  page;
        stamp_t stamp;
    } upd_t;

endpackage

// ===== rtl/lpr_cell.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement: frame cell
// Holds one frame and advances the scan beat by one position per cycle,
// folding in its tag match and its timestamp for the minimum search.
// ----------------------------------------------------------------------------
module lpr_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lpr_pkg::idx_t       cell_idx,
    input  lpr_pkg::token_t     tok_in,
    output lpr_pkg::token_t     tok_out,
    input  lpr_pkg::upd_t       upd
);
    import lpr_pkg::*;

    page_t  page_reg;
    logic   valid_reg;
    stamp_t stamp_reg;
    logic   tok_vld_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   match;
    logic   sel;

    assign match = valid_reg && (page_reg == tok_in.page);
    assign sel   = upd.en && (upd.slot == cell_idx);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.found)
        begin
            if (match)
            begin
                tok_next.found = 1'b1;
                tok_next.slot  = cell_idx;
            end
            else if (stamp_reg < tok_in.best)
            begin
                tok_next.best = stamp_reg;
                tok_next.slot = cell_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            stamp_reg   <= '0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            tok_vld_reg <= tok_in.vld;
            if (sel)
            begin
                valid_reg <= 1'b1;
                stamp_reg <= upd.stamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (sel)
        begin
            page_reg <= upd.page;
        end
    end

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.vld = tok_vld_reg;
    end

endmodule

// ===== rtl/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Page reference in, hit or fault out, over a chain of frame cells that share
// one scan beat for the tag match and the least-recent search.
// ----------------------------------------------------------------------------
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    page_number
//   result    out_valid / out_stall  hit, frame_index, fault_count
//   config    cfg_valid / cfg_ready  frame_count
//
// Active frames are frame_count clamped to 1..16. The scan beat moves one frame
// cell per cycle through the active cells, then the chosen frame is written.
// One reference is in the chain at a time; a result waits in the output
// register or a skid register while the next reference is scanned.
// A config beat waits until the scan beat has left every cell of the chain.
// Reset empties every frame, zeroes both counters and sets frame_count to 4.
// ----------------------------------------------------------------------------
module lru_page_replacement (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [15:0]                page_number,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [3:0]                 frame_index,
    output logic [31:0]                fault_count,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lpr_pkg::FC_W-1:0]   frame_count
);
    import lpr_pkg::*;

    token_t           tok_in  [FRAMES];
    token_t           tok_out [FRAMES];
    token_t           tok_head;
    token_t           tok_end;
    upd_t             upd;
    logic [FRAMES-1:0] chain_vld;

    logic [FC_W-1:0]  frame_count_reg;
    logic             busy_reg;
    stamp_t           use_counter_reg;
    stamp_t           use_counter_next;
    logic [31:0]      faults_reg;
    logic [31:0]      faults_next;
    idx_t             last_idx;
    logic             accept;
    logic             commit;
    logic             out_free;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [3:0]       out_idx_reg;
    logic [31:0]      out_faults_reg;
    logic             skid_valid_reg;
    logic             skid_hit_reg;
    logic [3:0]       skid_idx_reg;
    logic [31:0]      skid_faults_reg;

    assign in_stall  = busy_reg || skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = !busy_reg && (chain_vld == '0);

    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(frame_count_reg) > FRAMES)
        begin
            last_idx = IDX_W'(FRAMES - 1);
        end
        else
        begin
            last_idx = IDX_W'(frame_count_reg - 1'b1);
        end
    end

    always_comb
    begin
        tok_head.vld   = accept;
        tok_head.page  = PAGE_BITS'(page_number);
        tok_head.found = 1'b0;
        tok_head.slot  = '0;
        tok_head.best  = STAMP_MAX;
    end

    assign tok_in[0] = tok_head;

    genvar g;
    generate
        for (g = 0; g < FRAMES; g++)
        begin : g_cell
            if (g > 0)
            begin : g_link
                assign tok_in[g] = tok_out[g-1];
            end
            lpr_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (IDX_W'(g)),
                .tok_in   (tok_in[g]),
                .tok_out  (tok_out[g]),
                .upd      (upd)
            );
            assign chain_vld[g] = tok_out[g].vld;
        end
    endgenerate

    assign tok_end = tok_out[last_idx];
    assign commit  = tok_end.vld;

    assign use_counter_next = (use_counter_reg == STAMP_MAX) ? use_counter_reg
                                                             : use_counter_reg + 1'b1;
    always_comb
    begin
        faults_next = faults_reg;
        if (!tok_end.found && faults_reg != 32'hFFFF_FFFF)
        begin
            faults_next = faults_reg + 1'b1;
        end
    end

    always_comb
    begin
        upd.en    = commit;
        upd.slot  = tok_end.slot;
        upd.page  = tok_end.page;
        upd.stamp = use_counter_next;
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RST;
            busy_reg        <= 1'b0;
            use_counter_reg <= '0;
            faults_reg      <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                frame_count_reg <= frame_count;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (commit)
            begin
                busy_reg <= 1'b0;
            end
            if (commit)
            begin
                use_counter_reg <= use_counter_next;
                faults_reg      <= faults_next;
            end
            if (commit)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            if (out_free)
            begin
                out_hit_reg    <= tok_end.found;
                out_idx_reg    <= 4'(tok_end.slot);
                out_faults_reg <= faults_next;
            end
            else
            begin
                skid_hit_reg    <= tok_end.found;
                skid_idx_reg    <= 4'(tok_end.slot);
                skid_faults_reg <= faults_next;
            end
        end
        else if (out_free && skid_valid_reg)
        begin
            out_hit_reg    <= skid_hit_reg;
            out_idx_reg    <= skid_idx_reg;
            out_faults_reg <= skid_faults_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign frame_index = out_idx_reg;
    assign fault_count = out_faults_reg;

`ifndef ASSERT_OFF
    // A scan beat only leaves the chain while a reference is in flight.
    a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> busy_reg)
        else $error("scan beat completed with no reference in flight");

    // The skid register is only used behind a full output register.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat ahead of the output register");

    // An accepted reference keeps the chain busy until its write-back.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("chain not busy after an accepted reference");

    // No result beat is created while a stalled skid beat is pending.
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !skid_valid_reg)
        else $error("write-back with the skid register already full");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Sends page references through the block under several frame counts and
// predicts each hit or fault, frame index and fault count from a private copy
// of the frames. Both sides idle at random, and the result side holds off once
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PAGES  = 1350;
    localparam int FRAME_SLOTS   = lpr_pkg::FRAMES;

    typedef struct {
        logic        hit;
        logic [3:0]  frame_index;
        logic [31:0] fault_count;
    } outcome_t;

    class lru_tracker;
        bit [15:0]                 page_of[FRAME_SLOTS];
        bit                        used[FRAME_SLOTS];
        bit [31:0]                 stamp_of[FRAME_SLOTS];
        bit [31:0]                 use_ctr;
        bit [31:0]                 fault_ctr;
        bit [lpr_pkg::FC_W-1:0]    frame_limit;
        outcome_t                  awaited[$];
        int                        errors;

        function new();
            for (int i = 0; i < FRAME_SLOTS; i++)
            begin
                page_of[i]  = '0;
                used[i]     = 1'b0;
                stamp_of[i] = '0;
            end
            use_ctr     = '0;
            fault_ctr   = '0;
            frame_limit = lpr_pkg::FRAME_COUNT_RST;
            errors      = 0;
        endfunction

        function void set_frame_count(bit [lpr_pkg::FC_W-1:0] value);
            frame_limit = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function bit [31:0] bump_stamp();
            if (use_ctr != lpr_pkg::STAMP_MAX)
                use_ctr++;
            return use_ctr;
        endfunction

        function void note_page(bit [15:0] page);
            int       active;
            int       slot;
            bit       found;
            bit [31:0] oldest;
            outcome_t o;
            active = (frame_limit == 0) ? 1 :
                     (frame_limit > FRAME_SLOTS) ? FRAME_SLOTS : int'(frame_limit);
            slot  = 0;
            found = 1'b0;
            for (int i = 0; i < active; i++)
            begin
                if (!found && used[i] && page_of[i] == page)
                begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            if (found)
                stamp_of[slot] = bump_stamp();
            else
            begin
                if (fault_ctr != lpr_pkg::STAMP_MAX)
                    fault_ctr++;
                oldest = stamp_of[0];
                for (int i = 1; i < active; i++)
                begin
                    if (stamp_of[i] < oldest)
                    begin
                        oldest = stamp_of[i];
                        slot   = i;
                    end
                end
                page_of[slot]  = page;
                used[slot]     = 1'b1;
                stamp_of[slot] = bump_stamp();
            end
            o.hit         = found;
            o.frame_index = slot[3:0];
            o.fault_count = fault_ctr;
            awaited.push_back(o);
        endfunction

        function void check_outcome(logic hit, logic [3:0] frame_index,
                                    logic [31:0] fault_count);
            outcome_t o;
            if (awaited.size() == 0)
            begin
                $display("%0t: result beat with nothing expected (hit %0b frame %0d faults %0d)",
                         $time, hit, frame_index, fault_count);
                errors++;
                return;
            end
            o = awaited.pop_front();
            if (hit !== o.hit)
            begin
                $display("%0t: hit expected %0b actual %0b", $time, o.hit, hit);
                errors++;
            end
            if (frame_index !== o.frame_index)
            begin
                $display("%0t: frame_index expected %0d actual %0d",
                         $time, o.frame_index, frame_index);
                errors++;
            end
            if (fault_count !== o.fault_count)
            begin
                $display("%0t: fault_count expected %0d actual %0d",
                         $time, o.fault_count, fault_count);
                errors++;
            end
        endfunction
    endclass

    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       in_valid        = 1'b0;
    logic                       in_stall;
    logic [15:0]                page_number     = '0;
    logic                       out_valid;
    logic                       out_stall       = 1'b1;
    logic                       hit;
    logic [3:0]                 frame_index;
    logic [31:0]                fault_count;
    logic                       cfg_valid       = 1'b0;
    logic                       cfg_ready;
    logic [lpr_pkg::FC_W-1:0]   cfg_frame_count = '0;

    lru_tracker tracker = new();
    int         cycle_count    = 0;
    int         pages_accepted = 0;
    bit         no_idle        = 1'b0;
    logic       hold_off       = 1'b0;

    lru_page_replacement dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .page_number (page_number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .frame_index (frame_index),
        .fault_count (fault_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .frame_count (cfg_frame_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                tracker.check_outcome(hit, frame_index, fault_count);
                wait_left = no_idle ? 0 : $urandom_range(0, 7);
            end
            if (!rst_n || hold_off)
                out_stall <= 1'b1;
            else if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // The result side stops once while references keep coming, so the block backs up.
    initial
    begin
        wait (pages_accepted >= 500);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_page(input logic [15:0] page);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= page;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_page(page);
        pages_accepted++;
    endtask

    task automatic finish_burst();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [lpr_pkg::FC_W-1:0] value);
        cfg_valid       <= 1'b1;
        cfg_frame_count <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_frame_count(value);
    endtask

    initial
    begin
        int               fc_plan[8];
        int               random_sent;
        int               phase;
        int               setting;
        int               active;
        int               pool;
        int               base;
        int               count;
        logic [15:0]      page;
        fc_plan     = '{1, 16, 2, 17, 0, 8, 31, 3};
        random_sent = 0;
        phase       = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset frame count of four: fill in order, hits, then least-recent victims.
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'hFFFF);
        send_page(16'h0003);
        send_page(16'h5555);
        send_page(16'hAAAA);
        finish_burst();

        // A count of zero acts as one frame; the last page duplicates a frame outside it.
        write_frame_count(5'd0);
        send_page(16'h0007);
        send_page(16'h0007);
        send_page(16'h0008);
        send_page(16'hFFFF);
        finish_burst();

        // A count above the frame total acts as all frames; the duplicate hits lowest.
        write_frame_count(5'd31);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h8000);
        send_page(16'h0001);
        finish_burst();

        while (random_sent < RANDOM_PAGES)
        begin
            setting = (phase < 8) ? fc_plan[phase] : $urandom_range(0, 31);
            active  = (setting == 0) ? 1 : (setting > FRAME_SLOTS) ? FRAME_SLOTS : setting;
            pool    = active + $urandom_range(0, active + 2);
            case ($urandom_range(0, 3))
                0:       base = 0;
                1:       base = 65536 - pool;
                default: base = $urandom_range(0, 65536 - pool);
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(60, 140);
            if (count > RANDOM_PAGES - random_sent)
                count = RANDOM_PAGES - random_sent;
            write_frame_count(setting[lpr_pkg::FC_W-1:0]);
            for (int k = 0; k < count; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                    page = 16'(base + $urandom_range(0, pool - 1));
                else
                    page = 16'($urandom_range(0, 65535));
                send_page(page);
                random_sent++;
            end
            finish_burst();
            phase++;
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
